// ----- hdl/bqc_pkg.sv -----
// Shared types, widths and constants of the Q15 biquad cascade.
// Has no dependencies; the interfaces, the top level and the testbench use it.
`timescale 1ns / 1ps

package bqc_pkg;

  localparam int VALUE_W      = 16;
  localparam int INDEX_W      = 6;
  localparam int PROD_W       = 17;
  localparam int ACC_W        = 20;
  localparam int COEFS_PER_STAGE = 5;
  localparam int Q15_SHIFT    = 15;
  localparam int STAGES_W     = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  localparam logic signed [VALUE_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [VALUE_W-1:0] Q15_MIN = -16'sh8000;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam logic REG_IDX_ACTIVE_STAGES = 1'b0;
  localparam logic [STAGES_W-1:0] ACTIVE_STAGES_RESET = 4'd1;

  typedef logic signed [VALUE_W-1:0] q15_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_READ,
    PH_MUL_B0,
    PH_Y,
    PH_ACC1,
    PH_ACC2,
    PH_SUB1,
    PH_WB
  } phase_t;

  function automatic q15_t sat16(input acc_t v);
    q15_t r;
    if (v > ACC_W'(Q15_MAX)) begin
      r = Q15_MAX;
    end else if (v < ACC_W'(Q15_MIN)) begin
      r = Q15_MIN;
    end else begin
      r = v[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/bqc_if.sv -----
// Valid/ready channel interfaces of the biquad cascade: input items and results.
// Depends on bqc_pkg for the field widths.
`timescale 1ns / 1ps

interface bqc_in_if;
  import bqc_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [INDEX_W-1:0]  coef_index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, coef_index, value, input ready);
  modport sink   (input valid, mode, coef_index, value, output ready);
endinterface

interface bqc_out_if;
  import bqc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] filtered_sample;

  modport source (output valid, filtered_sample, input ready);
  modport sink   (input valid, filtered_sample, output ready);
endinterface

// ----- hdl/bqc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the coefficient table and the delay store.
`timescale 1ns / 1ps

module bqc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/biquad_cascade_q15_top.sv -----
// Top level of the Q15 biquad cascade in transposed direct form II.
// Depends on bqc_pkg, the channel interfaces in bqc_if and bqc_ram.
`timescale 1ns / 1ps
//
// The input channel carries items that either write one coefficient word
// (mode 1, slot stage*5 + k for b0, b1, b2, a1, a2) or present one sample
// (mode 0). A coefficient transfer is absorbed in its own cycle and gives no
// result. A sample runs through the active sections and gives one result
// on the output channel. The APB-style port holds active_stages at address 0.
// Each section steps through the phases READ, MUL_B0, Y, ACC1, ACC2, SUB1
// and WB on one shared 16x16 multiplier, which is fed from the coefficient
// RAM one word per cycle. A sample runs through N sections, where N is the
// clamped stage count; no new item is taken until its result is loaded.
// With N equal to zero the sample goes unfiltered into the output register.
// Reset clears the delay store through one valid bit per section, so no
// clearing pass is needed; coefficients must be written before use.
// A result waits in an output register; the next item may be taken while it
// waits, and a finished sample holds the block until the register is free.

module biquad_cascade_q15_top #(
  parameter int MAX_STAGES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bqc_in_if.sink                            in_ch,
  bqc_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bqc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bqc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bqc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import bqc_pkg::*;

  localparam int COEF_DEPTH = COEFS_PER_STAGE * MAX_STAGES;
  localparam int CAW = $clog2(COEF_DEPTH);
  localparam int SW  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int SCW = $clog2(MAX_STAGES + 1);
  localparam int IW  = (CAW > INDEX_W) ? CAW : INDEX_W;
  localparam int DLY_W = 2 * VALUE_W;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [STAGES_W-1:0] active_r;
  logic [SCW-1:0]      n_stages_r;
  logic [SCW-1:0]      n_clamp;
  logic [SCW-1:0]      stage_r;
  logic                stage_last;
  logic [CAW-1:0]      coef_addr_r;
  logic [MAX_STAGES-1:0] dvalid_r;
  logic                dval_q_r;

  q15_t  x_r, y_r, d1, d2, nd1, nd2, mul_b;
  prod_t prod_r;
  acc_t  acc1_r, acc2_r;
  logic signed [2*VALUE_W-1:0] product;

  logic              in_accept, cfg_write, out_load;
  logic              out_valid_r;
  q15_t              out_data_r;
  logic [IW-1:0]     slot_ext;

  logic              coef_we, coef_re;
  logic [CAW-1:0]    coef_waddr;
  logic [VALUE_W-1:0] coef_rdata;
  logic              dly_we, dly_re;
  logic [SW-1:0]     dly_addr;
  logic [DLY_W-1:0]  dly_wdata, dly_rdata;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_ACTIVE_STAGES)
                      ? CFG_DATA_W'(active_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_STAGES_RESET;
    end else if (cfg_write && cfg_paddr[2] == REG_IDX_ACTIVE_STAGES) begin
      active_r <= cfg_pwdata[STAGES_W-1:0];
    end
  end

  // Input decode.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign slot_ext    = IW'(in_ch.coef_index);
  assign coef_waddr  = slot_ext[CAW-1:0];
  assign coef_we     = in_accept && (in_ch.mode == MODE_COEF)
                       && (int'(in_ch.coef_index) < COEF_DEPTH);
  assign n_clamp     = (int'(active_r) > MAX_STAGES) ? SCW'(MAX_STAGES) : SCW'(active_r);
  assign stage_last  = (stage_r == n_stages_r - SCW'(1));

  // Memories.
  assign coef_re   = (state_r == ST_RUN) && (phase_r != PH_SUB1) && (phase_r != PH_WB);
  assign dly_re    = (state_r == ST_RUN) && (phase_r == PH_READ);
  assign dly_we    = (state_r == ST_RUN) && (phase_r == PH_WB);
  assign dly_addr  = stage_r[SW-1:0];
  assign dly_wdata = {nd1, nd2};

  bqc_ram #(.WIDTH(VALUE_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_ch.value),
    .re    (coef_re),
    .raddr (coef_addr_r),
    .rdata (coef_rdata)
  );

  bqc_ram #(.WIDTH(DLY_W), .DEPTH(MAX_STAGES)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_addr),
    .wdata (dly_wdata),
    .re    (dly_re),
    .raddr (dly_addr),
    .rdata (dly_rdata)
  );

  // Datapath: one shared multiplier, registered product.
  assign d1 = dval_q_r ? q15_t'(dly_rdata[DLY_W-1:VALUE_W]) : '0;
  assign d2 = dval_q_r ? q15_t'(dly_rdata[VALUE_W-1:0]) : '0;
  assign mul_b = (phase_r == PH_MUL_B0 || phase_r == PH_Y || phase_r == PH_ACC1) ? x_r : y_r;
  assign product = $signed(coef_rdata) * mul_b;
  assign nd1 = sat16(acc1_r);
  assign nd2 = sat16(acc2_r - ACC_W'(prod_r));

  always_ff @(posedge clk) begin
    prod_r <= product[2*VALUE_W-1:Q15_SHIFT];
    if (in_accept && in_ch.mode == MODE_SAMPLE) begin
      x_r <= in_ch.value;
    end
    if (state_r == ST_RUN) begin
      unique case (phase_r)
        PH_Y:    y_r    <= sat16(ACC_W'(prod_r) + ACC_W'(d1));
        PH_ACC1: acc1_r <= ACC_W'(prod_r) + ACC_W'(d2);
        PH_ACC2: acc2_r <= ACC_W'(prod_r);
        PH_SUB1: acc1_r <= acc1_r - ACC_W'(prod_r);
        PH_WB:   x_r    <= y_r;
        default: ;
      endcase
    end
    if (dly_re) begin
      dval_q_r <= dvalid_r[dly_addr];
    end
    if (out_load) begin
      out_data_r <= x_r;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_READ;
      stage_r     <= '0;
      n_stages_r  <= '0;
      coef_addr_r <= '0;
      dvalid_r    <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (in_accept && in_ch.mode == MODE_SAMPLE) begin
        n_stages_r  <= n_clamp;
        stage_r     <= '0;
        coef_addr_r <= '0;
      end else begin
        if (coef_re) begin
          coef_addr_r <= coef_addr_r + CAW'(1);
        end
        if (dly_we) begin
          stage_r            <= stage_r + SCW'(1);
          dvalid_r[dly_addr] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        phase_nxt = PH_READ;
        if (in_accept && in_ch.mode == MODE_SAMPLE) begin
          state_nxt = (n_clamp == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        unique case (phase_r)
          PH_READ:   phase_nxt = PH_MUL_B0;
          PH_MUL_B0: phase_nxt = PH_Y;
          PH_Y:      phase_nxt = PH_ACC1;
          PH_ACC1:   phase_nxt = PH_ACC2;
          PH_ACC2:   phase_nxt = PH_SUB1;
          PH_SUB1:   phase_nxt = PH_WB;
          PH_WB: begin
            phase_nxt = PH_READ;
            if (stage_last) begin
              state_nxt = ST_DONE;
            end
          end
          default:   phase_nxt = PH_READ;
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register.
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.filtered_sample = out_data_r;

  // The delay row is never read and written back in the same cycle.
  a_dly_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(dly_we && dly_re))
    else $error("delay store read and write overlap");

  // Coefficient reads stay inside the table.
  a_coef_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    coef_re |-> (int'(coef_addr_r) < COEF_DEPTH))
    else $error("coefficient read beyond the table");

  // The section counter never passes the clamped stage count while running.
  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (stage_r < n_stages_r))
    else $error("section counter out of range");

  // A new result only appears after a finished sample.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded without a finished sample");

endmodule

// ----- tb/sv/biquad_cascade_q15_top_test.sv -----
// Self-checking testbench of the Q15 biquad cascade: directed and random items, scoreboard.
// Depends on bqc_pkg, the channel interfaces in bqc_if and the biquad_cascade_q15_top RTL.
`timescale 1ns / 1ps

typedef enum int {
  K_B0,
  K_B1,
  K_B2,
  K_A1,
  K_A2
} coef_role_t;

class biquad_scoreboard #(int STAGES = 8);
  localparam int NSLOTS = bqc_pkg::COEFS_PER_STAGE * STAGES;

  bqc_pkg::q15_t coef[NSLOTS];
  bit coef_loaded[NSLOTS];
  bqc_pkg::q15_t delay_d1[STAGES];
  bqc_pkg::q15_t delay_d2[STAGES];
  logic [bqc_pkg::STAGES_W-1:0] stage_count;
  bqc_pkg::q15_t expected_samples[$];
  int errors;
  int n_samples;
  int n_coefs;
  int n_checked;

  function new();
    foreach (coef_loaded[i]) begin
      coef[i] = '0;
      coef_loaded[i] = 1'b0;
    end
    foreach (delay_d1[s]) begin
      delay_d1[s] = '0;
      delay_d2[s] = '0;
    end
    stage_count = bqc_pkg::ACTIVE_STAGES_RESET;
    errors = 0;
    n_samples = 0;
    n_coefs = 0;
    n_checked = 0;
  endfunction

  static function int q15_mul(bqc_pkg::q15_t a, bqc_pkg::q15_t b);
    int p;
    p = int'(a) * int'(b);
    return p >>> bqc_pkg::Q15_SHIFT;
  endfunction

  static function bqc_pkg::q15_t clamp_q15(int v);
    if (v > int'(bqc_pkg::Q15_MAX)) begin
      return bqc_pkg::Q15_MAX;
    end
    if (v < int'(bqc_pkg::Q15_MIN)) begin
      return bqc_pkg::Q15_MIN;
    end
    return bqc_pkg::q15_t'(v);
  endfunction

  function void set_stages(logic [bqc_pkg::STAGES_W-1:0] v);
    stage_count = v;
  endfunction

  function int used_stages();
    return (int'(stage_count) > STAGES) ? STAGES : int'(stage_count);
  endfunction

  function bit stage_ready(int s);
    for (int k = 0; k < bqc_pkg::COEFS_PER_STAGE; k++) begin
      if (!coef_loaded[s * bqc_pkg::COEFS_PER_STAGE + k]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function void note_item(logic mode, logic [bqc_pkg::INDEX_W-1:0] slot, bqc_pkg::q15_t val);
    int x;
    int y;
    int base;
    if (mode == bqc_pkg::MODE_COEF) begin
      n_coefs++;
      if (int'(slot) < NSLOTS) begin
        coef[slot] = val;
        coef_loaded[slot] = 1'b1;
      end
      return;
    end
    n_samples++;
    x = val;
    for (int s = 0; s < used_stages(); s++) begin
      base = s * bqc_pkg::COEFS_PER_STAGE;
      y = clamp_q15(q15_mul(coef[base + K_B0], bqc_pkg::q15_t'(x)) + delay_d1[s]);
      delay_d1[s] = clamp_q15(q15_mul(coef[base + K_B1], bqc_pkg::q15_t'(x))
                              - q15_mul(coef[base + K_A1], bqc_pkg::q15_t'(y)) + delay_d2[s]);
      delay_d2[s] = clamp_q15(q15_mul(coef[base + K_B2], bqc_pkg::q15_t'(x))
                              - q15_mul(coef[base + K_A2], bqc_pkg::q15_t'(y)));
      x = y;
    end
    expected_samples.push_back(bqc_pkg::q15_t'(x));
  endfunction

  function void report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endfunction

  function void check_result(bqc_pkg::q15_t got);
    bqc_pkg::q15_t want;
    if (expected_samples.size() == 0) begin
      report($sformatf("filtered_sample %0d with no sample pending", got));
      return;
    end
    want = expected_samples.pop_front();
    n_checked++;
    if (got !== want) begin
      report($sformatf("filtered_sample got %0d expected %0d", got, want));
    end
  endfunction
endclass

module biquad_cascade_q15_top_test;
  import bqc_pkg::*;

  localparam int MAX_STAGES = 8;
  localparam int NUM_SLOTS = COEFS_PER_STAGE * MAX_STAGES;
  localparam int CLK_PERIOD_NS = 12;
  localparam int SETTLE_CYCLES = 7 * MAX_STAGES + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 60;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ACTIVE_STAGES =
    CFG_ADDR_W'(4 * int'(REG_IDX_ACTIVE_STAGES));

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_hold_req;
  logic [STAGES_W-1:0] stage_plan [NUM_PHASES] =
    '{4'd8, 4'd15, 4'd3, 4'd0, 4'd1, 4'd8, 4'd9, 4'd5};

  biquad_scoreboard #(MAX_STAGES) sb;

  bqc_in_if  in_ch ();
  bqc_out_if out_ch ();

  biquad_cascade_q15_top #(
    .MAX_STAGES(MAX_STAGES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #(CLK_PERIOD_NS / 2) clk = ~clk;

  function automatic int idle_gap(bit enabled);
    int r;
    if (!enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic q15_t pick_extreme();
    case ($urandom_range(0, 3))
      0: return Q15_MAX;
      1: return Q15_MIN;
      2: return q15_t'(0);
      default: return q15_t'(-1);
    endcase
  endfunction

  function automatic q15_t coef_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return pick_extreme();
    end
    if (r < 60) begin
      return q15_t'(int'($urandom_range(0, 16383)) - 8192);
    end
    return q15_t'($urandom_range(0, 65535));
  endfunction

  function automatic q15_t sample_value();
    if ($urandom_range(0, 99) < 15) begin
      return pick_extreme();
    end
    return q15_t'($urandom_range(0, 65535));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer_item(logic mode, logic [INDEX_W-1:0] slot, q15_t val);
    int gap;
    gap = idle_gap(tx_idle_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.coef_index <= slot;
    in_ch.value      <= val;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(mode, slot, val);
    @(negedge clk);
  endtask

  task automatic offer_random_item();
    if ($urandom_range(0, 99) < 25) begin
      offer_item(MODE_COEF, INDEX_W'($urandom_range(0, 63)), coef_value());
    end else begin
      offer_item(MODE_SAMPLE, INDEX_W'($urandom), sample_value());
    end
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_samples.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_stage_count(logic [STAGES_W-1:0] v);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_ACTIVE_STAGES;
    cfg_pwdata  <= CFG_DATA_W'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_stages(v);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic load_missing_stages();
    for (int s = 0; s < sb.used_stages(); s++) begin
      if (!sb.stage_ready(s)) begin
        for (int k = 0; k < COEFS_PER_STAGE; k++) begin
          offer_item(MODE_COEF, INDEX_W'(s * COEFS_PER_STAGE + k), coef_value());
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.filtered_sample);
    end
  end

  initial begin : result_sink
    int stall;
    int held;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = idle_gap(rx_idle_on);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_SAMPLE;
    in_ch.coef_index = '0;
    in_ch.value      = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    rst_n            = 1'b0;
    tx_idle_on       = 1'b0;
    rx_idle_on       = 1'b0;
    rx_hold_req      = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer_item(MODE_COEF, INDEX_W'(K_B0), Q15_MAX);
    offer_item(MODE_COEF, INDEX_W'(K_B1), Q15_MIN);
    offer_item(MODE_COEF, INDEX_W'(K_B2), 16'sh4000);
    offer_item(MODE_COEF, INDEX_W'(K_A1), Q15_MIN);
    offer_item(MODE_COEF, INDEX_W'(K_A2), Q15_MAX);
    offer_item(MODE_COEF, INDEX_W'(NUM_SLOTS), q15_t'(-1));
    offer_item(MODE_COEF, {INDEX_W{1'b1}}, 16'sh5555);
    offer_item(MODE_SAMPLE, {INDEX_W{1'b1}}, Q15_MAX);
    offer_item(MODE_SAMPLE, '0, Q15_MIN);
    offer_item(MODE_SAMPLE, '0, q15_t'(0));
    offer_item(MODE_SAMPLE, INDEX_W'(K_A2), q15_t'(-1));
    offer_item(MODE_SAMPLE, '0, q15_t'(1));
    offer_item(MODE_SAMPLE, 6'h2A, 16'sh5A5A);
    offer_item(MODE_SAMPLE, 6'h15, 16'shA5A5);
    offer_item(MODE_COEF, INDEX_W'(K_B0), 16'sh2000);
    offer_item(MODE_SAMPLE, '0, 16'sh1234);
    offer_item(MODE_SAMPLE, '0, Q15_MIN);
    write_stage_count('0);
    offer_item(MODE_SAMPLE, '0, Q15_MAX);
    offer_item(MODE_SAMPLE, '0, Q15_MIN);
    offer_item(MODE_SAMPLE, {INDEX_W{1'b1}}, 16'sh00FF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle_on = (p % 3 != 0);
      rx_idle_on = (p % 4 != 0);
      write_stage_count(stage_plan[p]);
      load_missing_stages();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 10) begin
          rx_hold_req = 1'b1;
        end
        if (p == 2 && i == 30) begin
          wait_results_drained();
        end
        offer_random_item();
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_samples.size() != 0) begin
      sb.report($sformatf("%0d filtered samples never arrived", sb.expected_samples.size()));
    end
    $display("Covered %0d samples and %0d coefficient writes over %0d stage settings.",
             sb.n_samples, sb.n_coefs, NUM_PHASES + 2);
    $display("Checked %0d filtered results; %0d mismatches.", sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bqc_pkg.sv
hdl/bqc_if.sv
hdl/bqc_ram.sv
hdl/biquad_cascade_q15_top.sv
tb/sv/biquad_cascade_q15_top_test.sv
